// File: rtl/hpt_pkg.sv
// ----------------------------------------------------------------------------
// hpt_pkg
// Shared types, constants and helpers for the hot page tracker.
// ----------------------------------------------------------------------------
package hpt_pkg;

  // Table geometry
  localparam int PAGES    = 1024;
  localparam int LISTS    = 4;
  localparam int HOT_BITS = 16;

  localparam int PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int LIST_W = (LISTS > 1) ? $clog2(LISTS) : 1;

  // Word field widths at the ports
  localparam int IN_PAGE_W  = 10;
  localparam int CKPT_W     = 32;
  localparam int STATUS_W   = 3;
  localparam int OUT_HOT_W  = 16;
  localparam int OUT_LIST_W = 2;
  localparam int THR_W      = 16;
  localparam int CNT_W      = 11;

  localparam logic [THR_W-1:0]    THR_RESET = THR_W'(64);
  localparam logic [HOT_BITS-1:0] HOT_MAX   = '1;
  localparam logic [CNT_W-1:0]    CNT_MAX   = '1;
  localparam logic [LIST_W-1:0]   LIST_LAST = LIST_W'(LISTS - 1);
  // list number that matches the count value all ones (count wraps down)
  localparam logic [LIST_W-1:0]   LIST_AT_CNT_MAX = LIST_W'(((1 << CNT_W) - 1) % LISTS);
  localparam logic [PAGE_W-1:0]   PAGE_LAST = PAGE_W'(PAGES - 1);

  // Front queue
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  // Item kinds
  localparam logic KIND_ACCESS = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_COUNTED   = 3'd0,
    ST_SKIPPED   = 3'd1,
    ST_PROMOTED  = 3'd2,
    ST_REMOVED   = 3'd3,
    ST_UNTRACKED = 3'd4
  } status_t;

  // Back unit states
  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_EXEC
  } back_state_t;

  // Queued word
  typedef struct packed {
    logic              kind;
    logic [PAGE_W-1:0] page;
    logic [CKPT_W-1:0] ckpt;
  } item_t;

  // Back to front status
  typedef struct packed {
    logic pop;
    logic clearing;
  } back_status_t;

  // One table entry
  typedef struct packed {
    logic                valid;
    logic                active;
    logic [HOT_BITS-1:0] hotness;
    logic [CKPT_W-1:0]   ckpt;
    logic [LIST_W-1:0]   list;
  } tbl_entry_t;

  // Page index modulo PAGES by conditional subtraction, one bit per step
  function automatic logic [PAGE_W-1:0] page_reduce(input logic [IN_PAGE_W-1:0] v);
    logic [63:0] r;
    logic [63:0] m;
    r = 64'(v);
    for (int k = IN_PAGE_W - 1; k >= 0; k--) begin
      m = 64'(PAGES) << k;
      if (r >= m) begin
        r = r - m;
      end
    end
    return PAGE_W'(r);
  endfunction

endpackage

// File: rtl/hot_page_tracker_top.sv
// ----------------------------------------------------------------------------
// hot_page_tracker_top
// Per-page hotness tracker with promotion to active lists.
//
//   channel  | ports                                        | handshake
//   ---------+----------------------------------------------+------------------
//   input    | in_kind, in_page_index, in_ckpt_version      | start && !busy
//   result   | out_status, out_hotness_now, out_list_number,| out_valid, 1 cycle
//            | out_is_active                                |
//   config   | psel, penable, pwrite, paddr, pwdata, prdata | APB, pready = 1
//
// The back unit takes one word at a time: a table read, then an update and
// write-back on the single-port table memory, before it pops the next word.
// A word passes the queue, then the table read register; its result is
// registered. After reset the table is cleared, one entry per cycle;
// busy stays high meanwhile, configuration writes are still taken.
// busy also rises while the 2-entry queue is full. Results cannot be stalled.
// ----------------------------------------------------------------------------
module hot_page_tracker_top import hpt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // command channel
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_kind,
  input  logic [IN_PAGE_W-1:0]  in_page_index,
  input  logic [CKPT_W-1:0]     in_ckpt_version,
  // result channel
  output logic                  out_valid,
  output logic [STATUS_W-1:0]   out_status,
  output logic [OUT_HOT_W-1:0]  out_hotness_now,
  output logic [OUT_LIST_W-1:0] out_list_number,
  output logic                  out_is_active,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam logic REG_THRESHOLD = 1'b0;

  logic [THR_W-1:0] thr_r;
  logic             cfg_wr;
  back_status_t     bk_st;
  logic             q_valid;
  item_t            q_item;

  // Configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_THRESHOLD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_wr) begin
      thr_r <= pwdata[THR_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_THRESHOLD) ? 32'(thr_r) : '0;

  hpt_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .in_kind         (in_kind),
    .in_page_index   (in_page_index),
    .in_ckpt_version (in_ckpt_version),
    .busy            (busy),
    .bk_st           (bk_st),
    .q_valid         (q_valid),
    .q_item          (q_item)
  );

  hpt_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .hot_threshold   (thr_r),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .bk_st           (bk_st),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_hotness_now (out_hotness_now),
    .out_list_number (out_list_number),
    .out_is_active   (out_is_active)
  );

endmodule

// File: rtl/hpt_front.sv
// ----------------------------------------------------------------------------
// hpt_front
// Takes command words, reduces the page index and queues them for the back.
// ----------------------------------------------------------------------------
module hpt_front import hpt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 in_kind,
  input  logic [IN_PAGE_W-1:0] in_page_index,
  input  logic [CKPT_W-1:0]    in_ckpt_version,
  output logic                 busy,
  input  back_status_t         bk_st,
  output logic                 q_valid,
  output item_t                q_item
);

  item_t              q_mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  q_cnt_r, q_cnt_nxt;
  logic               push;
  item_t              new_item;

  // Accept unless the queue is full or the table is being cleared
  assign busy = (q_cnt_r == QCNT_W'(QDEPTH)) || bk_st.clearing;
  assign push = start && !busy;

  assign new_item.kind = in_kind;
  assign new_item.page = page_reduce(in_page_index);
  assign new_item.ckpt = in_ckpt_version;

  assign q_valid = (q_cnt_r != '0);
  assign q_item  = q_mem_r[rd_ptr_r];

  // Pointer and fill updates
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = bk_st.pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    q_cnt_nxt  = q_cnt_r;
    if (push && !bk_st.pop) begin
      q_cnt_nxt = q_cnt_r + 1'b1;
    end else if (!push && bk_st.pop) begin
      q_cnt_nxt = q_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      q_cnt_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      q_cnt_r  <= q_cnt_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

// File: rtl/hpt_back.sv
// ----------------------------------------------------------------------------
// hpt_back
// Owns the page table: clears it after reset, then reads one entry per queued
// word, writes it back when it changes and registers the result.
// ----------------------------------------------------------------------------
module hpt_back import hpt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [THR_W-1:0]      hot_threshold,
  input  logic                  q_valid,
  input  item_t                 q_item,
  output back_status_t          bk_st,
  output logic                  out_valid,
  output logic [STATUS_W-1:0]   out_status,
  output logic [OUT_HOT_W-1:0]  out_hotness_now,
  output logic [OUT_LIST_W-1:0] out_list_number,
  output logic                  out_is_active
);

  tbl_entry_t tbl_mem [PAGES];

  back_state_t         state_r, state_nxt;
  logic [PAGE_W-1:0]   clr_cnt_r, clr_cnt_nxt;
  item_t               cur_r;
  tbl_entry_t          rd_data_r;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [LIST_W-1:0]   lptr_r, lptr_nxt;

  logic                out_valid_r;
  status_t             out_status_r;
  logic [HOT_BITS-1:0] out_hot_r;
  logic [LIST_W-1:0]   out_list_r;
  logic                out_act_r;

  logic                mem_re, mem_we;
  logic [PAGE_W-1:0]   mem_waddr;
  tbl_entry_t          mem_wdata;

  logic                res_valid;
  status_t             res_status;
  logic [HOT_BITS-1:0] res_hot;
  logic [LIST_W-1:0]   res_list;
  logic                res_act;

  tbl_entry_t          e;
  logic                base_act;
  logic [HOT_BITS-1:0] base_hot;
  logic [HOT_BITS-1:0] hot_new;
  logic                promote;
  logic                do_inc, do_dec;

  assign e        = rd_data_r;
  assign base_act = e.valid && e.active;
  assign base_hot = e.valid ? e.hotness : '0;
  assign hot_new  = (base_hot == HOT_MAX) ? HOT_MAX : base_hot + 1'b1;
  assign promote  = (32'(hot_new) >= 32'(hot_threshold)) && !base_act;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_CLEAR: if (clr_cnt_r == PAGE_LAST) state_nxt = BK_IDLE;
      BK_IDLE:  if (q_valid) state_nxt = BK_EXEC;
      BK_EXEC:  state_nxt = BK_IDLE;
      default:  state_nxt = BK_CLEAR;
    endcase
  end

  // Outputs: table access, result and counters
  always_comb begin
    mem_re       = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = cur_r.page;
    mem_wdata    = '0;
    bk_st        = '0;
    clr_cnt_nxt  = clr_cnt_r;
    res_valid    = 1'b0;
    res_status   = ST_COUNTED;
    res_hot      = '0;
    res_list     = '0;
    res_act      = 1'b0;
    do_inc       = 1'b0;
    do_dec       = 1'b0;
    unique case (state_r)
      BK_CLEAR: begin
        bk_st.clearing = 1'b1;
        mem_we         = 1'b1;
        mem_waddr      = clr_cnt_r;
        clr_cnt_nxt    = clr_cnt_r + 1'b1;
      end
      BK_IDLE: begin
        bk_st.pop = q_valid;
        mem_re    = q_valid;
      end
      BK_EXEC: begin
        res_valid = 1'b1;
        if (cur_r.kind == KIND_REMOVE) begin
          if (!e.valid) begin
            res_status = ST_UNTRACKED;
          end else begin
            res_status = ST_REMOVED;
            mem_we     = 1'b1;
            mem_wdata  = e;
            mem_wdata.valid   = 1'b0;
            mem_wdata.active  = 1'b0;
            mem_wdata.hotness = '0;
            do_dec     = e.active;
          end
        end else if (e.valid && (e.ckpt == cur_r.ckpt)) begin
          res_status = ST_SKIPPED;
          res_hot    = e.hotness;
          res_act    = e.active;
          res_list   = e.active ? e.list : '0;
        end else begin
          mem_we            = 1'b1;
          mem_wdata.valid   = 1'b1;
          mem_wdata.active  = base_act || promote;
          mem_wdata.hotness = hot_new;
          mem_wdata.ckpt    = cur_r.ckpt;
          mem_wdata.list    = promote ? lptr_r : e.list;
          do_inc            = promote;
          res_status        = promote ? ST_PROMOTED : ST_COUNTED;
          res_hot           = hot_new;
          res_act           = base_act || promote;
          res_list          = (base_act || promote) ? mem_wdata.list : '0;
        end
      end
      default: ;
    endcase

    // Active count and its list number, kept in step across wraps
    cnt_nxt  = cnt_r;
    lptr_nxt = lptr_r;
    if (do_inc) begin
      cnt_nxt  = cnt_r + 1'b1;
      lptr_nxt = ((cnt_r == CNT_MAX) || (lptr_r == LIST_LAST)) ? '0 : lptr_r + 1'b1;
    end else if (do_dec) begin
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        lptr_nxt = LIST_AT_CNT_MAX;
      end else begin
        lptr_nxt = (lptr_r == '0) ? LIST_LAST : lptr_r - 1'b1;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_CLEAR;
      clr_cnt_r   <= '0;
      cnt_r       <= '0;
      lptr_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      cnt_r       <= cnt_nxt;
      lptr_r      <= lptr_nxt;
      out_valid_r <= res_valid;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (bk_st.pop) begin
      cur_r <= q_item;
    end
    if (res_valid) begin
      out_status_r <= res_status;
      out_hot_r    <= res_hot;
      out_list_r   <= res_list;
      out_act_r    <= res_act;
    end
  end

  // Page table memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      tbl_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data_r <= tbl_mem[q_item.page];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_hotness_now = OUT_HOT_W'(out_hot_r);
  assign out_list_number = OUT_LIST_W'(out_list_r);
  assign out_is_active   = out_act_r;

endmodule

// File: rtl/hpt_checker.sv
// ----------------------------------------------------------------------------
// hpt_checker
// Port-level checks on the hot page tracker, bound to the top level.
// ----------------------------------------------------------------------------
module hpt_checker import hpt_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  busy,
  input logic                  out_valid,
  input logic [STATUS_W-1:0]   out_status,
  input logic [OUT_HOT_W-1:0]  out_hotness_now,
  input logic [OUT_LIST_W-1:0] out_list_number,
  input logic                  out_is_active
);

  // Table clear holds off commands right after reset
  a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> busy)
    else $error("busy low right after reset");

  // Back unit finishes one word before it takes the next, so results never come back to back
  a_result_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("results in back-to-back cycles");

  // Removes report zero fields
  a_remove_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_REMOVED || out_status == ST_UNTRACKED)
    |-> (out_hotness_now == '0) && (out_list_number == '0) && !out_is_active)
    else $error("remove word with nonzero fields");

  // Inactive pages carry list zero
  a_inactive_list: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_active |-> out_list_number == '0)
    else $error("list number on inactive page");

  // Promotion leaves the page active
  a_promote_active: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_PROMOTED) |-> out_is_active)
    else $error("promoted page not active");

endmodule

bind hot_page_tracker_top hpt_checker u_hpt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_status      (out_status),
  .out_hotness_now (out_hotness_now),
  .out_list_number (out_list_number),
  .out_is_active   (out_is_active)
);

// File: tb/sv/tb_hot_page_tracker_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hot_page_tracker_top
// Self-checking bench for the hot page tracker. A queue of words feeds a
// clocked driver; every accepted word runs through a local copy of the page
// table, and the one-cycle result strobes are compared against it in order.
// Phases cover reset threshold, threshold zero, small thresholds with random
// traffic, and the top threshold with a long count run on one page.
// ----------------------------------------------------------------------------
module tb_hot_page_tracker_top import hpt_pkg::*; ();

  localparam int         CLK_PERIOD        = 4;
  localparam logic [2:0] REG_HOT_THRESHOLD = 3'd0;
  localparam int         STALL_LIMIT       = 4000;
  localparam int         DRAIN_CYCLES      = 8;

  // one result word as the ports show it
  typedef struct packed {
    status_t                status;
    logic [OUT_HOT_W-1:0]   hotness;
    logic [OUT_LIST_W-1:0]  list;
    logic                   active;
  } page_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic                  in_kind = 1'b0;
  logic [IN_PAGE_W-1:0]  in_page_index = '0;
  logic [CKPT_W-1:0]     in_ckpt_version = '0;
  logic                  out_valid;
  logic [STATUS_W-1:0]   out_status;
  logic [OUT_HOT_W-1:0]  out_hotness_now;
  logic [OUT_LIST_W-1:0] out_list_number;
  logic                  out_is_active;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [2:0]            paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  // page table as the bench sees it
  logic                page_valid  [PAGES];
  logic                page_active [PAGES];
  logic [HOT_BITS-1:0] page_hot    [PAGES];
  logic [CKPT_W-1:0]   page_ckpt   [PAGES];
  logic [LIST_W-1:0]   page_list   [PAGES];
  logic [CNT_W-1:0]    promoted_cnt;
  logic [THR_W-1:0]    threshold_now;

  item_t                pending_words[$];
  page_result_t         due_results[$];
  int unsigned          send_gap_pct = 32;
  logic                 word_taken = 1'b0;
  int unsigned          quiet_cycles = 0;
  int unsigned          error_count = 0;
  logic [CKPT_W-1:0]    ckpt_now = '0;
  logic [IN_PAGE_W-1:0] last_pg = '0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  hot_page_tracker_top u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_kind        (in_kind),
    .in_page_index  (in_page_index),
    .in_ckpt_version(in_ckpt_version),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_hotness_now(out_hotness_now),
    .out_list_number(out_list_number),
    .out_is_active  (out_is_active),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // Apply one word to the page table, return the result it should produce
  function automatic page_result_t track_word(input item_t w);
    page_result_t      r;
    logic [PAGE_W-1:0] p;
    p         = w.page;
    r.status  = ST_COUNTED;
    r.hotness = '0;
    r.list    = '0;
    r.active  = 1'b0;
    if (w.kind == KIND_REMOVE) begin
      if (!page_valid[p]) begin
        r.status = ST_UNTRACKED;
      end else begin
        if (page_active[p]) begin
          promoted_cnt = promoted_cnt - 1'b1;
        end
        page_active[p] = 1'b0;
        page_hot[p]    = '0;
        page_valid[p]  = 1'b0;
        r.status       = ST_REMOVED;
      end
      return r;
    end
    if (page_valid[p] && page_ckpt[p] == w.ckpt) begin
      // already counted in this checkpoint
      r.status = ST_SKIPPED;
    end else begin
      if (!page_valid[p]) begin
        page_valid[p]  = 1'b1;
        page_active[p] = 1'b0;
        page_hot[p]    = '0;
      end
      if (page_hot[p] != HOT_MAX) begin
        page_hot[p] = page_hot[p] + 1'b1;
      end
      page_ckpt[p] = w.ckpt;
      if (page_hot[p] >= threshold_now && !page_active[p]) begin
        page_active[p] = 1'b1;
        page_list[p]   = LIST_W'(promoted_cnt % LISTS);
        promoted_cnt   = promoted_cnt + 1'b1;
        r.status       = ST_PROMOTED;
      end
    end
    r.hotness = OUT_HOT_W'(page_hot[p]);
    r.active  = page_active[p];
    r.list    = page_active[p] ? OUT_LIST_W'(page_list[p]) : '0;
    return r;
  endfunction

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  task automatic queue_word(input logic kd, input logic [IN_PAGE_W-1:0] pg,
                            input logic [CKPT_W-1:0] ck);
    item_t w;
    w.kind = kd;
    w.page = PAGE_W'(pg);
    w.ckpt = ck;
    pending_words.push_back(w);
    last_pg = pg;
  endtask

  // Random traffic: mostly a small set of hot pages so promotions happen,
  // back-to-back repeats of one page, some full-range pages and removes
  task automatic add_random_words(input int unsigned n);
    logic [IN_PAGE_W-1:0] pg;
    logic                 kd;
    repeat (n) begin
      if ($urandom_range(0, 99) < 35) begin
        ckpt_now = $urandom;
      end
      case ($urandom_range(0, 4))
        0, 1:    pg = IN_PAGE_W'($urandom_range(0, 15));
        2:       pg = IN_PAGE_W'(PAGES - 16 + $urandom_range(0, 15));
        3:       pg = IN_PAGE_W'($urandom);
        default: pg = last_pg;
      endcase
      kd = ($urandom_range(0, 99) < 12) ? KIND_REMOVE : KIND_ACCESS;
      queue_word(kd, pg, ckpt_now);
    end
  endtask

  // Hold off until every queued word is sent and every result is back
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_words.size() != 0 || start || due_results.size() != 0);
  endtask

  task automatic write_threshold(input logic [THR_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= REG_HOT_THRESHOLD;
    pwdata  <= 32'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Driver: hold a word until taken, else maybe present the next one
  always @(negedge clk) begin : drive_words
    item_t nxt;
    if (rst_n && !(start && !word_taken)) begin
      if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
        nxt             = pending_words.pop_front();
        start           <= 1'b1;
        in_kind         <= nxt.kind;
        in_page_index   <= IN_PAGE_W'(nxt.page);
        in_ckpt_version <= nxt.ckpt;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: track config writes, predict accepted words, check results
  always @(posedge clk) begin : sample_words
    item_t        w;
    page_result_t want;
    word_taken <= rst_n && start && !busy;
    if (rst_n) begin
      if (psel && penable && pwrite && pready && paddr == REG_HOT_THRESHOLD) begin
        threshold_now = pwdata[THR_W-1:0];
      end
      if (start && !busy) begin
        w.kind = in_kind;
        // table holds 1024 pages, so the index needs no reduction
        w.page = PAGE_W'(in_page_index);
        w.ckpt = in_ckpt_version;
        due_results.push_back(track_word(w));
      end
      if (out_valid) begin
        if (due_results.size() == 0) begin
          $display("%0t: result with none expected, status %0d", $time, out_status);
          error_count++;
        end else begin
          want = due_results.pop_front();
          compare_field("status", want.status, out_status);
          compare_field("hotness_now", want.hotness, out_hotness_now);
          compare_field("list_number", want.list, out_list_number);
          compare_field("is_active", want.active, out_is_active);
        end
      end
    end
  end

  // Watchdog on cycles with no word, result or register write
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (psel && penable && pwrite)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("hot_page_tracker_top verification failed");
      $finish;
    end
  end

  initial begin : run_test
    int unsigned i;
    for (i = 0; i < PAGES; i++) begin
      page_valid[i]  = 1'b0;
      page_active[i] = 1'b0;
      page_hot[i]    = '0;
      page_ckpt[i]   = '0;
      page_list[i]   = '0;
    end
    promoted_cnt  = '0;
    threshold_now = THR_RESET;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset threshold: count, skip, remove, untracked remove, bit extremes
    send_gap_pct = 32;
    queue_word(KIND_ACCESS, 10'd0, 32'h0000_0000);
    queue_word(KIND_ACCESS, 10'd0, 32'h0000_0000);
    queue_word(KIND_ACCESS, 10'd0, 32'hFFFF_FFFF);
    queue_word(KIND_REMOVE, 10'd0, 32'h0000_0000);
    queue_word(KIND_REMOVE, 10'd0, 32'hFFFF_FFFF);
    queue_word(KIND_ACCESS, 10'h3FF, 32'hFFFF_FFFF);
    queue_word(KIND_REMOVE, 10'h3FF, 32'h0000_0000);
    queue_word(KIND_REMOVE, 10'h2AA, 32'h0000_0000);
    queue_word(KIND_ACCESS, 10'h155, 32'h5555_5555);
    queue_word(KIND_ACCESS, 10'h2AA, 32'hAAAA_AAAA);
    wait_drained();

    // threshold zero: first count promotes, lists rotate, remove of active
    write_threshold(16'd0);
    queue_word(KIND_ACCESS, 10'd3, 32'd1);
    queue_word(KIND_ACCESS, 10'd4, 32'd1);
    queue_word(KIND_ACCESS, 10'd5, 32'd1);
    queue_word(KIND_ACCESS, 10'd6, 32'd1);
    queue_word(KIND_ACCESS, 10'd7, 32'd1);
    queue_word(KIND_ACCESS, 10'd3, 32'd2);
    queue_word(KIND_ACCESS, 10'd3, 32'd2);
    queue_word(KIND_REMOVE, 10'd4, 32'd2);
    queue_word(KIND_ACCESS, 10'd8, 32'd1);
    queue_word(KIND_ACCESS, 10'd4, 32'd1);
    queue_word(KIND_ACCESS, 10'h155, 32'h5555_5555);
    queue_word(KIND_ACCESS, 10'h155, 32'd0);
    wait_drained();

    write_threshold(16'd2);
    add_random_words(400);
    wait_drained();

    send_gap_pct = 48;
    write_threshold(16'd1);
    add_random_words(400);
    wait_drained();

    send_gap_pct = 0;
    write_threshold(16'd5);
    add_random_words(400);
    wait_drained();

    // top threshold: one page counted over many checkpoints, never promoted
    write_threshold(16'hFFFF);
    queue_word(KIND_REMOVE, 10'd9, 32'd0);
    for (i = 1; i <= 24; i++) begin
      queue_word(KIND_ACCESS, 10'd9, i);
    end
    queue_word(KIND_ACCESS, 10'd9, 32'd24);
    queue_word(KIND_REMOVE, 10'd9, 32'd0);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("hot_page_tracker_top verification clean");
    end else begin
      $display("hot_page_tracker_top verification failed");
    end
    $finish;
  end

endmodule
